/* src/tsad_pkg.sv */
package tsad_pkg;

  // Detector modes, as reported on detector_state
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_FAR_ONLY  = 3'd1,
    MODE_NEAR_ONLY = 3'd2,
    MODE_BOTH      = 3'd3,
    MODE_APPROACH  = 3'd4
  } mode_e;

  // Input word commands; the fourth code does nothing
  typedef enum logic [1:0] {
    CMD_SAMPLE      = 2'd0,
    CMD_RESTART     = 2'd1,
    CMD_CLEAR_STATS = 2'd2
  } cmd_e;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_CONFIRM_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_SIMULTANEOUS    = 2'd1;
  localparam logic [1:0] CFG_PATTERN_TIMEOUT = 2'd2;

  localparam logic [31:0] CONFIRM_WINDOW_RST  = 32'd5000;
  localparam logic [31:0] SIMULTANEOUS_RST    = 32'd500;
  localparam logic [31:0] PATTERN_TIMEOUT_RST = 32'd10000;

  typedef struct packed {
    logic [31:0] confirm_window;
    logic [31:0] simultaneous;
    logic [31:0] pattern_timeout;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic        confirmed;
    logic [31:0] mode_start;
    logic [31:0] far_rise;
    logic [31:0] near_rise;
    logic [31:0] confirm_time;
    logic [15:0] approach_cnt;
    logic [15:0] unknown_cnt;
    logic        prev_far;
    logic        prev_near;
  } state_t;

  localparam state_t STATE_RST = '{
    mode:         MODE_IDLE,
    confirmed:    1'b0,
    mode_start:   32'd0,
    far_rise:     32'd0,
    near_rise:    32'd0,
    confirm_time: 32'd0,
    approach_cnt: 16'd0,
    unknown_cnt:  16'd0,
    prev_far:     1'b0,
    prev_near:    1'b0
  };

  // One result word as the core hands it to the output register
  typedef struct packed {
    mode_e       mode;
    logic        approaching;
    logic [31:0] confidence;
    logic [15:0] approach_total;
    logic [15:0] unknown_total;
  } result_t;

endpackage

/* src/tsad_cfg_regs.sv */
module tsad_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [1:0]         wr_index_i,
  input  logic [31:0]        wr_data_i,
  output tsad_pkg::cfg_t     cfg_o
);

  tsad_pkg::cfg_t cfg_q;
  tsad_pkg::cfg_t cfg_d;

  // Decode the write; an unknown index leaves everything as it is
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        tsad_pkg::CFG_CONFIRM_WINDOW:  cfg_d.confirm_window  = wr_data_i;
        tsad_pkg::CFG_SIMULTANEOUS:    cfg_d.simultaneous    = wr_data_i;
        tsad_pkg::CFG_PATTERN_TIMEOUT: cfg_d.pattern_timeout = wr_data_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_window  <= tsad_pkg::CONFIRM_WINDOW_RST;
      cfg_q.simultaneous    <= tsad_pkg::SIMULTANEOUS_RST;
      cfg_q.pattern_timeout <= tsad_pkg::PATTERN_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/tsad_core.sv */
module tsad_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  tsad_pkg::cfg_t       cfg_i,
  input  logic [1:0]           command_i,
  input  logic                 far_i,
  input  logic                 near_i,
  input  logic [31:0]          time_i,
  output tsad_pkg::result_t    res_o
);

  tsad_pkg::state_t state_q;
  tsad_pkg::state_t state_d;

  function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
    abs_gap = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    sat_inc = (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic tsad_pkg::state_t go_idle(input tsad_pkg::state_t s);
    tsad_pkg::state_t r;
    r              = s;
    r.mode         = tsad_pkg::MODE_IDLE;
    r.confirmed    = 1'b0;
    r.mode_start   = 32'd0;
    r.confirm_time = 32'd0;
    go_idle = r;
  endfunction

  // Next state: sample (far edge, near edge, falls, settle, timeout, in that order), restart, clear stats
  always_comb begin
    state_d = state_q;
    case (tsad_pkg::cmd_e'(command_i))
      tsad_pkg::CMD_SAMPLE: begin
        // far rise
        if (far_i && !state_q.prev_far) begin
          state_d.far_rise = time_i;
          if (near_i && state_d.near_rise != 32'd0 &&
              abs_gap(time_i, state_d.near_rise) < cfg_i.simultaneous) begin
            state_d.unknown_cnt = sat_inc(state_d.unknown_cnt);
          end else if (state_d.mode == tsad_pkg::MODE_IDLE) begin
            state_d.mode       = tsad_pkg::MODE_FAR_ONLY;
            state_d.mode_start = time_i;
          end
        end
        // near rise
        if (near_i && !state_q.prev_near) begin
          state_d.near_rise = time_i;
          if (far_i && state_d.far_rise != 32'd0 &&
              abs_gap(time_i, state_d.far_rise) < cfg_i.simultaneous) begin
            state_d.unknown_cnt = sat_inc(state_d.unknown_cnt);
          end else if (state_d.mode == tsad_pkg::MODE_IDLE) begin
            state_d.mode        = tsad_pkg::MODE_NEAR_ONLY;
            state_d.mode_start  = time_i;
            state_d.unknown_cnt = sat_inc(state_d.unknown_cnt);
          end else if (state_d.mode == tsad_pkg::MODE_FAR_ONLY &&
                       state_d.far_rise != 32'd0) begin
            if ((time_i - state_d.far_rise) <= cfg_i.confirm_window) begin
              state_d.mode         = tsad_pkg::MODE_APPROACH;
              state_d.confirmed    = 1'b1;
              state_d.confirm_time = time_i;
              state_d.approach_cnt = sat_inc(state_d.approach_cnt);
            end else begin
              state_d.unknown_cnt = sat_inc(state_d.unknown_cnt);
            end
          end
        end
        // falls with both sensors clear
        if (!far_i && state_q.prev_far && !near_i &&
            state_d.mode != tsad_pkg::MODE_IDLE && !state_d.confirmed) begin
          state_d = go_idle(state_d);
        end
        if (!near_i && state_q.prev_near && !far_i &&
            state_d.mode != tsad_pkg::MODE_IDLE) begin
          state_d = go_idle(state_d);
        end
        // settle on the current levels
        case (state_d.mode)
          tsad_pkg::MODE_FAR_ONLY: begin
            if (far_i && near_i) state_d.mode = tsad_pkg::MODE_BOTH;
            else if (!far_i) state_d = go_idle(state_d);
          end
          tsad_pkg::MODE_NEAR_ONLY: begin
            if (far_i && near_i) state_d.mode = tsad_pkg::MODE_BOTH;
            else if (!near_i) state_d = go_idle(state_d);
          end
          tsad_pkg::MODE_BOTH, tsad_pkg::MODE_APPROACH: begin
            if (!far_i && !near_i) state_d = go_idle(state_d);
          end
          default: ;
        endcase
        // drop a pattern that has lasted too long
        if (state_d.mode != tsad_pkg::MODE_IDLE &&
            (time_i - state_d.mode_start) > cfg_i.pattern_timeout) begin
          state_d.unknown_cnt = sat_inc(state_d.unknown_cnt);
          state_d = go_idle(state_d);
        end
        state_d.prev_far  = far_i;
        state_d.prev_near = near_i;
      end
      tsad_pkg::CMD_RESTART: begin
        state_d           = go_idle(state_q);
        state_d.prev_far  = far_i;
        state_d.prev_near = near_i;
      end
      tsad_pkg::CMD_CLEAR_STATS: begin
        state_d.approach_cnt = 16'd0;
        state_d.unknown_cnt  = 16'd0;
      end
      default: state_d = state_q;
    endcase
  end

  // Result word from the updated state
  always_comb begin
    res_o.mode           = state_d.mode;
    res_o.approaching    = state_d.confirmed;
    res_o.confidence     = (state_d.confirmed && state_d.confirm_time != 32'd0) ?
                           (time_i - state_d.confirm_time) : 32'd0;
    res_o.approach_total = state_d.approach_cnt;
    res_o.unknown_total  = state_d.unknown_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsad_pkg::STATE_RST;
    end else if (step_en_i) begin
      state_q <= state_d;
    end
  end

endmodule

/* src/two_sensor_approach_detector_unit.sv */
// A word accepted into the input register steps the detector when the result register is
// empty or being taken, and its result is then held in the result register until taken.
// Throughput: one word per cycle while the result port is not stalled; the state updates as each word steps.
// Reset (asynchronous, active low) returns the detector to idle, clears the
// counters and rise times, and loads the default window, simultaneous and
// timeout values.
module two_sensor_approach_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic        far_active_i,
  input  logic        near_active_i,
  input  logic [31:0] time_ms_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  detector_state_o,
  output logic        approaching_o,
  output logic [31:0] confidence_ms_o,
  output logic [15:0] approach_total_o,
  output logic [15:0] unknown_total_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  tsad_pkg::cfg_t    cfg;
  tsad_pkg::result_t res;

  logic        in_valid_q;
  logic        in_valid_d;
  logic [1:0]  cmd_q;
  logic        far_q;
  logic        near_q;
  logic [31:0] time_q;
  logic        out_valid_q;
  logic        out_valid_d;
  tsad_pkg::result_t res_q;

  logic out_free;
  logic step;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  tsad_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held word when the result register is empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;
    out_valid_d = out_free ? step : out_valid_q;
  end

  tsad_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step),
    .cfg_i     (cfg),
    .command_i (cmd_q),
    .far_i     (far_q),
    .near_i    (near_q),
    .time_i    (time_q),
    .res_o     (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payloads
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= command_i;
      far_q  <= far_active_i;
      near_q <= near_active_i;
      time_q <= time_ms_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign detector_state_o = 3'(res_q.mode);
  assign approaching_o    = res_q.approaching;
  assign confidence_ms_o  = res_q.confidence;
  assign approach_total_o = res_q.approach_total;
  assign unknown_total_o  = res_q.unknown_total;

endmodule

/* src/tsad_checker.sv */
module tsad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  detector_state_o,
  input logic        approaching_o,
  input logic [31:0] confidence_ms_o
);

  // A stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(detector_state_o))
    else $error("result word dropped or changed while stalled");

  // Confirmation and the approaching mode go together
  a_confirm_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (approaching_o ==
                     (detector_state_o == 3'(tsad_pkg::MODE_APPROACH))))
    else $error("approaching flag disagrees with detector state");

  // No confidence time without confirmation
  a_conf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !approaching_o |-> confidence_ms_o == 32'd0)
    else $error("confidence reported while unconfirmed");

  // Only defined modes are reported
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> detector_state_o <= 3'(tsad_pkg::MODE_APPROACH))
    else $error("undefined detector state");

endmodule

bind two_sensor_approach_detector_unit tsad_checker u_tsad_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .detector_state_o (detector_state_o),
  .approaching_o    (approaching_o),
  .confidence_ms_o  (confidence_ms_o)
);
